@@ design/ors_pkg.sv @@
// ----------------------------------------------------------------------------
// ors_pkg
// Shared constants, operation and status codes, and the crc-8 bit step for
// the 1-wire search-rom enumerator.
// ----------------------------------------------------------------------------
`default_nettype none

package ors_pkg;

    // sizes
    localparam int ORS_MAX_DEVICES = 8;
    localparam int ORS_ID_W        = 64;
    localparam int ORS_CRC_BITS    = 56;
    localparam int ORS_CRC_W       = 8;

    // reflected dallas polynomial
    localparam logic [ORS_CRC_W-1:0] ORS_CRC_POLY = 8'h8C;

    // last bit slot of a pass
    localparam logic [5:0] ORS_LAST_BIT = 6'(ORS_ID_W - 1);

    // operation codes
    localparam logic [1:0] OP_RESTART  = 2'd0;
    localparam logic [1:0] OP_BIT_PAIR = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;

    // pass status codes
    localparam logic [2:0] ST_RUNNING    = 3'd0;
    localparam logic [2:0] ST_FOUND_MORE = 3'd1;
    localparam logic [2:0] ST_FOUND_LAST = 3'd2;
    localparam logic [2:0] ST_NO_RESP    = 3'd3;
    localparam logic [2:0] ST_CRC_ERR    = 3'd4;
    localparam logic [2:0] ST_ZERO_ID    = 3'd5;

    // one lsb-first step of the crc shift register
    function automatic logic [ORS_CRC_W-1:0] crc_step(
        input logic [ORS_CRC_W-1:0] crc,
        input logic                 din
    );
        logic fb;
        fb = crc[0] ^ din;
        return (crc >> 1) ^ (fb ? ORS_CRC_POLY : '0);
    endfunction

endpackage

`default_nettype wire

@@ design/ors_ram.sv @@
// ----------------------------------------------------------------------------
// ors_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ors_ram import ors_pkg::*; #(
    parameter  int WIDTH = ORS_ID_W,
    parameter  int DEPTH = ORS_MAX_DEVICES,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ design/onewire_rom_search_engine.sv @@
// A bit pair, restart or ignored word goes through S_EMIT; a table read waits in S_READ_WAIT first.
// The last bit slot of a pass that finds an id with room left adds the sorted
// insert: a scan up to the insert slot, a shift of the entries above it and a
// write of the new id, one table access at a time over one read and one write port.
// One word in flight; the next is taken once the result is in the output reg.
// Reset clears the search state and the count; table contents are undefined.
// ----------------------------------------------------------------------------
// onewire_rom_search_engine
// 1-wire search-rom enumerator: answers each bit pair with the direction bit,
// tracks conflicts as a stack, checks crc-8 and keeps found ids sorted.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_rom_search_engine import ors_pkg::*; #(
    parameter int MAX_DEVICES = ORS_MAX_DEVICES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic        i_id_bit,
    input  wire logic        i_complement_bit,
    input  wire logic [2:0]  i_entry_index,
    // output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_dir_bit,
    output logic             o_pass_done,
    output logic [2:0]       o_pass_status,
    output logic             o_search_finished,
    output logic [3:0]       o_device_count,
    output logic [2:0]       o_insert_position,
    output logic [63:0]      o_rom_value
);

    localparam int AW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int CW = $clog2(MAX_DEVICES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DEVICES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_WAIT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT_NEW,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [ORS_ID_W-1:0]    r_marks;
    logic [ORS_ID_W-1:0]    r_path;
    logic [5:0]             r_bitpos;
    logic [ORS_CRC_W-1:0]   r_crc;
    logic [CW-1:0]          r_count;
    logic                   r_finished;
    logic [AW-1:0]          r_idx;
    logic [AW-1:0]          r_pos;

    // pending result
    logic                   r_res_wbit;
    logic                   r_res_done;
    logic [2:0]             r_res_status;
    logic [2:0]             r_res_ins;
    logic [ORS_ID_W-1:0]    r_res_rom;

    // output register
    logic                   r_o_valid;
    logic                   r_o_wbit;
    logic                   r_o_done;
    logic [2:0]             r_o_status;
    logic                   r_o_fin;
    logic [3:0]             r_o_count;
    logic [2:0]             r_o_ins;
    logic [ORS_ID_W-1:0]    r_o_rom;

    logic                   in_accept;
    logic                   rd_ok;

    // outcome of an accepted word
    t_state                 n_state;
    logic                   n_res_wbit;
    logic                   n_res_done;
    logic [2:0]             n_res_status;
    logic [ORS_ID_W-1:0]    n_res_rom;
    logic                   n_finished;

    // table port
    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic [ORS_ID_W-1:0]    ram_wr_data;
    logic                   ram_rd_en;
    logic [AW-1:0]          ram_rd_addr;
    logic [ORS_ID_W-1:0]    ram_rd_data;

    // bit slot decision
    logic [ORS_ID_W-1:0]    slot_t;
    logic [ORS_ID_W-1:0]    ge_mask;
    logic [ORS_ID_W-1:0]    gt_mask;
    logic                   marks_ge;
    logic                   marks_gt;
    logic                   conflict;
    logic                   slot_bit;
    logic [ORS_ID_W-1:0]    slot_marks;
    logic [ORS_ID_W-1:0]    slot_path;
    logic [ORS_CRC_W-1:0]   crc_in;
    logic [ORS_CRC_W-1:0]   slot_crc;
    logic                   crc_bad;

    assign o_stall   = (r_state != S_IDLE);
    assign in_accept = i_valid && !o_stall;
    assign rd_ok     = (int'(i_entry_index) < int'(r_count)) &&
                       (int'(i_entry_index) < MAX_DEVICES);

    // conflict stack and path update for the current slot
    always_comb begin
        slot_t   = ORS_ID_W'(1) << r_bitpos;
        ge_mask  = ~(slot_t - ORS_ID_W'(1));
        gt_mask  = ge_mask & ~slot_t;
        marks_ge = |(r_marks & ge_mask);
        marks_gt = |(r_marks & gt_mask);
        conflict = !i_id_bit && !i_complement_bit;

        slot_marks = r_marks;
        if (conflict) begin
            if (!marks_ge) begin
                // new conflict: push and take 0
                slot_bit   = 1'b0;
                slot_marks = r_marks | slot_t;
            end else if (!marks_gt) begin
                // highest pending conflict: take 1 and pop
                slot_bit   = 1'b1;
                slot_marks = r_marks & ~slot_t;
            end else begin
                slot_bit   = r_path[r_bitpos];
            end
        end else begin
            slot_bit = i_id_bit;
        end

        slot_path = slot_bit ? (r_path | slot_t) : (r_path & ~slot_t);

        // crc runs over the low 56 id bits as they arrive
        crc_in   = (r_bitpos == '0) ? '0 : r_crc;
        slot_crc = (int'(r_bitpos) < ORS_CRC_BITS) ? crc_step(crc_in, slot_bit) : r_crc;
        crc_bad  = (r_crc != slot_path[ORS_ID_W-1 -: ORS_CRC_W]);
    end

    // result and next step for the word at the input
    always_comb begin
        n_state      = S_EMIT;
        n_res_wbit   = 1'b0;
        n_res_done   = 1'b0;
        n_res_status = ST_RUNNING;
        n_res_rom    = '0;
        n_finished   = r_finished;
        case (i_operation)
            OP_RESTART: begin
                n_finished = 1'b0;
            end
            OP_READ: begin
                if (rd_ok) begin
                    n_state = S_READ_WAIT;
                end
            end
            OP_BIT_PAIR: begin
                if (!r_finished) begin
                    if (i_id_bit && i_complement_bit) begin
                        // no device answered
                        n_res_done   = 1'b1;
                        n_res_status = ST_NO_RESP;
                        n_finished   = 1'b1;
                    end else begin
                        n_res_wbit = slot_bit;
                        if (r_bitpos == ORS_LAST_BIT) begin
                            // pass end checks
                            n_res_done = 1'b1;
                            n_res_rom  = slot_path;
                            if (crc_bad) begin
                                n_res_status = ST_CRC_ERR;
                                n_finished   = 1'b1;
                            end else if (slot_path == '0) begin
                                n_res_status = ST_ZERO_ID;
                                n_finished   = 1'b1;
                            end else begin
                                if (slot_marks == '0) begin
                                    n_res_status = ST_FOUND_LAST;
                                    n_finished   = 1'b1;
                                end else begin
                                    n_res_status = ST_FOUND_MORE;
                                end
                                if (r_count < MAX_CNT) begin
                                    n_state = S_SCAN_RD;
                                end else begin
                                    n_finished = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // table port control
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_idx;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                ram_rd_en   = in_accept && (i_operation == OP_READ) && rd_ok;
                ram_rd_addr = AW'(i_entry_index);
            end
            S_SCAN_RD: begin
                ram_rd_en   = (CW'(r_idx) != r_count);
            end
            S_SHIFT_RD: begin
                ram_rd_en   = (r_idx != r_pos);
                ram_rd_addr = r_idx - AW'(1);
            end
            S_SHIFT_WR: begin
                ram_wr_en   = 1'b1;
            end
            S_PUT_NEW: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_pos;
                ram_wr_data = r_path;
            end
            default: begin
            end
        endcase
    end

    ors_ram #(
        .WIDTH (ORS_ID_W),
        .DEPTH (MAX_DEVICES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // sequencer, search state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_marks    <= '0;
            r_path     <= '0;
            r_bitpos   <= '0;
            r_crc      <= '0;
            r_count    <= '0;
            r_finished <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_o_valid && !i_stall && r_state != S_EMIT) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_res_wbit   <= n_res_wbit;
                        r_res_done   <= n_res_done;
                        r_res_status <= n_res_status;
                        r_res_ins    <= '0;
                        r_res_rom    <= n_res_rom;
                        r_finished   <= n_finished;
                        r_idx        <= '0;
                        r_state      <= n_state;
                        case (i_operation)
                            OP_RESTART: begin
                                r_marks  <= '0;
                                r_path   <= '0;
                                r_bitpos <= '0;
                                r_count  <= '0;
                            end
                            OP_BIT_PAIR: begin
                                if (!r_finished) begin
                                    if (i_id_bit && i_complement_bit) begin
                                        r_bitpos <= '0;
                                    end else begin
                                        r_marks  <= slot_marks;
                                        r_path   <= slot_path;
                                        r_crc    <= slot_crc;
                                        r_bitpos <= (r_bitpos == ORS_LAST_BIT) ?
                                                    '0 : r_bitpos + 6'd1;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                S_READ_WAIT: begin
                    r_res_rom <= ram_rd_data;
                    r_state   <= S_EMIT;
                end

                // find the first entry not below the new id
                S_SCAN_RD: begin
                    if (CW'(r_idx) == r_count) begin
                        r_pos   <= r_idx;
                        r_state <= S_SHIFT_RD;
                    end else begin
                        r_state <= S_SCAN_CMP;
                    end
                end

                S_SCAN_CMP: begin
                    if (r_path <= ram_rd_data) begin
                        r_pos   <= r_idx;
                        r_idx   <= AW'(r_count);
                        r_state <= S_SHIFT_RD;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_SCAN_RD;
                    end
                end

                // move the upper entries up by one, top first
                S_SHIFT_RD: begin
                    r_state <= (r_idx == r_pos) ? S_PUT_NEW : S_SHIFT_WR;
                end

                S_SHIFT_WR: begin
                    r_idx   <= r_idx - AW'(1);
                    r_state <= S_SHIFT_RD;
                end

                S_PUT_NEW: begin
                    r_count   <= r_count + CW'(1);
                    r_res_ins <= 3'(r_pos);
                    if ((r_count + CW'(1)) >= MAX_CNT) begin
                        r_finished <= 1'b1;
                    end
                    r_state   <= S_EMIT;
                end

                S_EMIT: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid  <= 1'b1;
                        r_o_wbit   <= r_res_wbit;
                        r_o_done   <= r_res_done;
                        r_o_status <= r_res_status;
                        r_o_fin    <= r_finished;
                        r_o_count  <= 4'(r_count);
                        r_o_ins    <= r_res_ins;
                        r_o_rom    <= r_res_rom;
                        r_state    <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid           = r_o_valid;
    assign o_dir_bit         = r_o_wbit;
    assign o_pass_done       = r_o_done;
    assign o_pass_status     = r_o_status;
    assign o_search_finished = r_o_fin;
    assign o_device_count    = r_o_count;
    assign o_insert_position = r_o_ins;
    assign o_rom_value       = r_o_rom;

endmodule

`default_nettype wire

@@ design/ors_chk.sv @@
// ----------------------------------------------------------------------------
// ors_chk
// Port-level checks on the result words of the search-rom enumerator.
// ----------------------------------------------------------------------------
`default_nettype none

module ors_chk import ors_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_dir_bit,
    input wire logic        o_pass_done,
    input wire logic [2:0]  o_pass_status,
    input wire logic        o_search_finished,
    input wire logic [3:0]  o_device_count,
    input wire logic [2:0]  o_insert_position,
    input wire logic [63:0] o_rom_value
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_dir_bit) && $stable(o_pass_done) &&
            $stable(o_pass_status) && $stable(o_search_finished) &&
            $stable(o_device_count) && $stable(o_insert_position) && $stable(o_rom_value))
        else $error("stalled result word changed");

    // status is only reported at the end of a pass
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pass_done |-> o_pass_status == ST_RUNNING)
        else $error("pass status without pass end");

    // a terminal pass outcome always finishes the search
    a_terminal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_pass_status == ST_FOUND_LAST || o_pass_status == ST_NO_RESP ||
            o_pass_status == ST_CRC_ERR || o_pass_status == ST_ZERO_ID)
        |-> o_search_finished)
        else $error("terminal status without finish");

    // no direction bit, no slot and no id on a no-response pass
    a_no_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pass_status == ST_NO_RESP
        |-> !o_dir_bit && o_insert_position == 3'd0 && o_rom_value == 64'd0)
        else $error("no-response word carries data");

endmodule

bind onewire_rom_search_engine ors_chk u_ors_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_dir_bit         (o_dir_bit),
    .o_pass_done       (o_pass_done),
    .o_pass_status     (o_pass_status),
    .o_search_finished (o_search_finished),
    .o_device_count    (o_device_count),
    .o_insert_position (o_insert_position),
    .o_rom_value       (o_rom_value)
);

`default_nettype wire
